[src/rrds_pkg.sv]
// Shared types and constants of the round-robin delay scheduler.
package rrds_pkg;

    // Fixed widths of the beat fields.
    localparam int CMD_W      = 2;
    localparam int TASK_ID_W  = 2;
    localparam int DELAY_IN_W = 16;
    localparam int CHOSEN_W   = 2;

    typedef logic [CMD_W-1:0]             cmd_raw_t;
    typedef logic [TASK_ID_W-1:0]         task_id_t;
    typedef logic signed [DELAY_IN_W-1:0] delay_in_t;
    typedef logic [CHOSEN_W-1:0]          chosen_t;

    // Command codes; the fourth code is unused and does nothing.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_YIELD    = 2'd2
    } cmd_t;

endpackage

[src/rrds_if.sv]
// Handshake channels of the scheduler: command beats in, result beats out.
interface rrds_cmd_if
    import rrds_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_raw_t  command;
    task_id_t  task_id;
    delay_in_t delay_ticks;

    modport source (output valid, output command, output task_id, output delay_ticks,
                    input ready);
    modport sink   (input valid, input command, input task_id, input delay_ticks,
                    output ready);
endinterface

interface rrds_res_if
    import rrds_pkg::*;
();
    logic    valid;
    logic    ready;
    chosen_t chosen_task;
    logic    task_found;

    modport source (output valid, output chosen_task, output task_found, input ready);
    modport sink   (input valid, input chosen_task, input task_found, output ready);
endinterface

[src/round_robin_delay_scheduler.sv]
// Round-robin scheduler with per-task tick delays, one result beat per command beat.
//
//  channel   dir   fields                                  accepted when
//  cmd_ch    in    command, task_id, delay_ticks           valid && ready
//  res_ch    out   chosen_task, task_found                 valid && ready
//
// A command beat is captured in an input register; its work is then done by one
// short step of logic (counter update or rotating priority search) that writes the
// result register and the task state. Throughput is one beat per cycle while the
// result is not stalled. Reset clears all counters (every task ready), the scan
// pointer and both valid flags. A stalled result holds the input register, and the
// input side takes a new beat only when the input register is free or moving on.
module round_robin_delay_scheduler
    import rrds_pkg::*;
#(
    parameter int NUM_TASKS  = 4,
    parameter int DELAY_BITS = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    rrds_cmd_if.sink   cmd_ch,
    rrds_res_if.source res_ch
);

    localparam int PTR_W = $clog2(NUM_TASKS);

    typedef logic [PTR_W-1:0]            ptr_t;
    typedef logic [PTR_W:0]              ptr_ext_t;
    typedef logic signed [DELAY_BITS-1:0] delay_t;
    typedef logic signed [32:0]           wide_t;

    localparam wide_t SAT_HI = (wide_t'(1) <<< (DELAY_BITS - 1)) - wide_t'(1);
    localparam wide_t SAT_LO = -SAT_HI - wide_t'(1);

    // Input stage.
    logic      in_valid_reg;
    cmd_raw_t  cmd_reg;
    task_id_t  tid_reg;
    delay_in_t delay_reg;

    // Result stage.
    logic    out_valid_reg;
    chosen_t chosen_reg;
    logic    found_reg;

    // Task state.
    delay_t task_delays_reg [NUM_TASKS];
    delay_t task_delays_next [NUM_TASKS];
    ptr_t   scan_pointer_reg;
    ptr_t   scan_pointer_next;

    logic   out_free;
    logic   advance;

    logic [NUM_TASKS-1:0] ready_vec;
    logic     found;
    ptr_t     found_idx;
    ptr_ext_t probe;
    wide_t    delay_wide;
    wide_t    delay_sat;
    delay_t   delay_val;

    // Handshake: the result register frees when empty or taken.
    assign out_free     = !out_valid_reg || res_ch.ready;
    assign advance      = in_valid_reg && out_free;
    assign cmd_ch.ready = !in_valid_reg || out_free;

    // Capture the command beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ch.ready)
        begin
            in_valid_reg <= cmd_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            cmd_reg   <= cmd_ch.command;
            tid_reg   <= cmd_ch.task_id;
            delay_reg <= cmd_ch.delay_ticks;
        end
    end

    // Which tasks have a counter of exactly zero.
    always_comb
    begin
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            ready_vec[i] = (task_delays_reg[i] == '0);
        end
    end

    // Rotating priority search starting at the scan pointer.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        probe     = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            probe = {1'b0, scan_pointer_reg} + ptr_ext_t'(i);
            if (probe >= ptr_ext_t'(NUM_TASKS))
            begin
                probe = probe - ptr_ext_t'(NUM_TASKS);
            end
            if (!found && ready_vec[probe[PTR_W-1:0]])
            begin
                found     = 1'b1;
                found_idx = probe[PTR_W-1:0];
            end
        end
    end

    // Requested delay, clamped to the counter range.
    always_comb
    begin
        delay_wide = wide_t'(delay_reg);
        if (delay_wide > SAT_HI)
        begin
            delay_sat = SAT_HI;
        end
        else if (delay_wide < SAT_LO)
        begin
            delay_sat = SAT_LO;
        end
        else
        begin
            delay_sat = delay_wide;
        end
        delay_val = delay_sat[DELAY_BITS-1:0];
    end

    // Next task state for the command in the input register.
    always_comb
    begin
        task_delays_next  = task_delays_reg;
        scan_pointer_next = scan_pointer_reg;
        unique case (cmd_reg)
            CMD_TICK:
            begin
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    if (!task_delays_reg[i][DELAY_BITS-1] && (task_delays_reg[i] != '0))
                    begin
                        task_delays_next[i] = task_delays_reg[i] - delay_t'(1);
                    end
                end
            end
            CMD_DISPATCH:
            begin
                if (found)
                begin
                    if (found_idx == ptr_t'(NUM_TASKS - 1))
                    begin
                        scan_pointer_next = '0;
                    end
                    else
                    begin
                        scan_pointer_next = found_idx + ptr_t'(1);
                    end
                end
            end
            CMD_YIELD:
            begin
                // A task number beyond the task count matches no slot.
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    if (32'(tid_reg) == i)
                    begin
                        task_delays_next[i] = delay_val;
                    end
                end
            end
            default:
            begin
                task_delays_next  = task_delays_reg;
                scan_pointer_next = scan_pointer_reg;
            end
        endcase
    end

    // State and result register update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                task_delays_reg[i] <= '0;
            end
            scan_pointer_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                task_delays_reg  <= task_delays_next;
                scan_pointer_reg <= scan_pointer_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if ((cmd_reg == CMD_DISPATCH) && found)
            begin
                chosen_reg <= chosen_t'(found_idx);
                found_reg  <= 1'b1;
            end
            else
            begin
                chosen_reg <= '0;
                found_reg  <= 1'b0;
            end
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.chosen_task = chosen_reg;
    assign res_ch.task_found  = found_reg;

`ifndef SYNTH
    // A result without a found task always reports task zero.
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (chosen_reg == '0))
        else $error("result without a found task has nonzero chosen_task");

    // The scan pointer never leaves the task range.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scan_pointer_reg) < NUM_TASKS)
        else $error("scan pointer out of range");

    // A stalled result keeps the input stage from moving on.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ch.ready && in_valid_reg) |=> (in_valid_reg && $stable(cmd_reg)))
        else $error("input stage moved while the result was stalled");

    // A successful dispatch reports the task the search picked.
    a_dispatch_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd_reg == CMD_DISPATCH) && found)
            |=> (found_reg && (chosen_reg == chosen_t'($past(found_idx)))))
        else $error("dispatch result does not match the search");
`endif

endmodule
